>>> rtl/core/dhcp6_relay_option_locator_macros.svh
// assertion macros for the dhcpv6 relay option locator
// used by the top level only; needs nothing else
`ifndef DHCP6_RELAY_OPTION_LOCATOR_MACROS_SVH
`define DHCP6_RELAY_OPTION_LOCATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DHCP6ROL_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("dhcp6rol assertion failed");

// next-cycle implication, disabled while in reset
`define DHCP6ROL_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("dhcp6rol assertion failed");

`endif

>>> rtl/core/dhcp6rol_pkg.sv
// shared types and constants of the dhcpv6 relay option locator
// no dependencies
`timescale 1ns / 1ps

package dhcp6rol_pkg;

    localparam int BUF_BYTES_DEF = 2048;
    localparam int MAX_RELAY_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int LEVEL_W  = 7;
    localparam int CODE_W   = 16;
    localparam int OFFSET_W = 11;
    localparam int DEPTH_W  = 6;
    localparam int LEN_W    = 17;

    localparam int MSG_HDR_BYTES   = 4;
    localparam int RELAY_HDR_BYTES = 34;
    localparam int OPT_HDR_BYTES   = 4;

    localparam logic [7:0]  TYPE_RELAY_FORW = 8'd12;
    localparam logic [7:0]  TYPE_RELAY_REPL = 8'd13;
    localparam logic [15:0] CODE_RELAY_MSG  = 16'd9;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_DEPTH = 2'd1,
        CMD_MSG   = 2'd2,
        CMD_FIND  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [LEVEL_W-1:0]   level;
        logic [CODE_W-1:0]    code;
        logic                 any;
        logic                 has_after;
        logic [OFFSET_W-1:0]  after;
    } query_t;

    typedef struct packed {
        logic                 found;
        logic [DEPTH_W-1:0]   depth;
        logic [OFFSET_W-1:0]  offset;
        logic [CODE_W-1:0]    code;
        logic [15:0]          length;
    } result_t;

endpackage

>>> rtl/core/dhcp6rol_if.sv
// request and response channel interfaces of the dhcpv6 relay option locator
// depends on nothing
`timescale 1ns / 1ps

interface dhcp6rol_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [6:0]  target_level;
    logic [15:0] option_code;
    logic        match_any;
    logic        has_after;
    logic [10:0] after_offset;

    modport source (output valid, command, data_byte, last_byte, target_level,
                    option_code, match_any, has_after, after_offset, input ready);
    modport sink (input valid, command, data_byte, last_byte, target_level,
                  option_code, match_any, has_after, after_offset, output ready);
endinterface

interface dhcp6rol_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [5:0]  relay_depth;
    logic [10:0] result_offset;
    logic [15:0] result_code;
    logic [15:0] result_length;
    logic        truncated;

    modport source (output valid, found, relay_depth, result_offset, result_code,
                    result_length, truncated, input ready);
    modport sink (input valid, found, relay_depth, result_offset, result_code,
                  result_length, truncated, output ready);
endinterface

>>> rtl/core/dhcp6rol_store.sv
// packet byte memory, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module dhcp6rol_store #(
    parameter int BUF_BYTES = 2048
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(BUF_BYTES)-1:0] wr_addr,
    input  logic [7:0]                   wr_data,
    input  logic [$clog2(BUF_BYTES)-1:0] rd_addr,
    output logic [7:0]                   rd_data
);

    logic [7:0] mem [BUF_BYTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/dhcp6rol_walker.sv
// option chain walker: depth pass, then header or option pass over the store
// depends on dhcp6rol_pkg
`timescale 1ns / 1ps

module dhcp6rol_walker #(
    parameter int BUF_BYTES = 2048,
    parameter int MAX_RELAY = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  dhcp6rol_pkg::query_t         query,
    input  logic [$clog2(BUF_BYTES):0]   packet_length,
    output logic [$clog2(BUF_BYTES)-1:0] rd_addr,
    input  logic [7:0]                   rd_data,
    input  logic                         out_free,
    output logic                         idle,
    output logic                         res_valid,
    output dhcp6rol_pkg::result_t        result
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int PW = AW + 1;
    localparam int LW = dhcp6rol_pkg::LEN_W;
    localparam int DW = dhcp6rol_pkg::DEPTH_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_TYPE_RD  = 7'b0000010,
        S_TYPE_CHK = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_HDR      = 7'b0010000,
        S_HDR_CHK  = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic                  pass_cmd_reg, pass_cmd_next;
    logic                  mode_find_reg, mode_find_next;
    dhcp6rol_pkg::query_t  q_reg, q_next;
    logic [PW-1:0]         msg_reg, msg_next;
    logic [LW-1:0]         len_reg, len_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic [PW-1:0]         opt_reg, opt_next;
    logic [LW-1:0]         rem_reg, rem_next;
    logic [PW-1:0]         opt0_reg, opt0_next;
    logic [LW-1:0]         rem0_reg, rem0_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [31:0]           hdr_reg, hdr_next;
    logic [7:0]            type_reg, type_next;
    logic [DW-1:0]         rdepth_reg, rdepth_next;
    dhcp6rol_pkg::result_t res_reg, res_next;

    logic [LW-1:0] plen_ext;
    logic          is_relay;
    logic          lvl_def;
    logic [DW-1:0] lvl;
    logic          depth_ge;
    logic [15:0]   hdr_code;
    logic [15:0]   hdr_len;
    logic [LW-1:0] size;
    logic          fits;
    logic [PW-1:0] hdr_addr;
    logic [PW-1:0] area_hdr;

    assign plen_ext = LW'(packet_length);
    assign is_relay = (rd_data == dhcp6rol_pkg::TYPE_RELAY_FORW)
                   || (rd_data == dhcp6rol_pkg::TYPE_RELAY_REPL);
    assign lvl_def  = ~q_reg.level[dhcp6rol_pkg::LEVEL_W-1];
    assign lvl      = q_reg.level[DW-1:0];
    assign depth_ge = depth_reg >= lvl;
    assign hdr_code = hdr_reg[31:16];
    assign hdr_len  = hdr_reg[15:0];
    assign size     = LW'(hdr_len) + LW'(dhcp6rol_pkg::OPT_HDR_BYTES);
    assign fits     = rem_reg >= size;
    assign hdr_addr = opt_reg + PW'(cnt_reg);
    assign area_hdr = is_relay ? PW'(dhcp6rol_pkg::RELAY_HDR_BYTES)
                               : PW'(dhcp6rol_pkg::MSG_HDR_BYTES);

    always_comb
    begin
        rd_addr = msg_reg[AW-1:0];
        if (state_reg == S_HDR)
        begin
            rd_addr = hdr_addr[AW-1:0];
        end
    end

    always_comb
    begin
        logic f_fail;
        logic f_dep_end;
        logic f_msg_end;
        logic f_nf;
        logic [7:0] cur_type;

        state_next     = state_reg;
        pass_cmd_next  = pass_cmd_reg;
        mode_find_next = mode_find_reg;
        q_next         = q_reg;
        msg_next       = msg_reg;
        len_next       = len_reg;
        depth_next     = depth_reg;
        opt_next       = opt_reg;
        rem_next       = rem_reg;
        opt0_next      = opt0_reg;
        rem0_next      = rem0_reg;
        cnt_next       = cnt_reg;
        hdr_next       = hdr_reg;
        type_next      = type_reg;
        rdepth_next    = rdepth_reg;
        res_next       = res_reg;
        res_valid      = 1'b0;
        f_fail         = 1'b0;
        f_dep_end      = 1'b0;
        f_msg_end      = 1'b0;
        f_nf           = 1'b0;
        cur_type       = (state_reg == S_TYPE_CHK) ? rd_data : type_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    q_next        = query;
                    msg_next      = '0;
                    len_next      = plen_ext;
                    depth_next    = '0;
                    pass_cmd_next = 1'b0;
                    state_next    = S_TYPE_RD;
                end
            end
            S_TYPE_RD:
            begin
                state_next = S_TYPE_CHK;
            end
            S_TYPE_CHK:
            begin
                type_next = rd_data;
                if (!pass_cmd_reg || q_reg.cmd == dhcp6rol_pkg::CMD_MSG)
                begin
                    if (depth_reg == DW'(MAX_RELAY)
                        || len_reg < LW'(dhcp6rol_pkg::RELAY_HDR_BYTES) || !is_relay
                        || (pass_cmd_reg && lvl_def && depth_ge))
                    begin
                        f_dep_end = !pass_cmd_reg;
                        f_msg_end = pass_cmd_reg;
                    end
                    else
                    begin
                        opt_next       = msg_reg + PW'(dhcp6rol_pkg::RELAY_HDR_BYTES);
                        rem_next       = len_reg - LW'(dhcp6rol_pkg::RELAY_HDR_BYTES);
                        mode_find_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
                else
                begin
                    if (depth_reg > DW'(MAX_RELAY)
                        || len_reg < LW'(dhcp6rol_pkg::MSG_HDR_BYTES)
                        || (is_relay && len_reg < LW'(dhcp6rol_pkg::RELAY_HDR_BYTES)))
                    begin
                        f_nf = 1'b1;
                    end
                    else
                    begin
                        opt_next   = msg_reg + area_hdr;
                        rem_next   = len_reg - LW'(area_hdr);
                        opt0_next  = msg_reg + area_hdr;
                        rem0_next  = len_reg - LW'(area_hdr);
                        state_next = S_SCAN;
                        if (is_relay && !(lvl_def && depth_ge))
                        begin
                            mode_find_next = 1'b0;
                        end
                        else if (lvl_def && depth_reg != lvl)
                        begin
                            f_nf = 1'b1;
                        end
                        else
                        begin
                            mode_find_next = 1'b1;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (rem_reg < LW'(dhcp6rol_pkg::OPT_HDR_BYTES))
                begin
                    f_fail = !mode_find_reg;
                    f_nf   = mode_find_reg;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                if (cnt_reg != 3'd0)
                begin
                    hdr_next = {hdr_reg[23:0], rd_data};
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = S_HDR_CHK;
                end
            end
            S_HDR_CHK:
            begin
                if (!fits)
                begin
                    f_fail = !mode_find_reg;
                    f_nf   = mode_find_reg;
                end
                else if (!mode_find_reg && hdr_code == dhcp6rol_pkg::CODE_RELAY_MSG)
                begin
                    // step into the relayed message
                    len_next   = LW'(hdr_len);
                    msg_next   = opt_reg + PW'(dhcp6rol_pkg::OPT_HDR_BYTES);
                    depth_next = depth_reg + DW'(1);
                    state_next = S_TYPE_RD;
                    if (pass_cmd_reg && q_reg.cmd == dhcp6rol_pkg::CMD_MSG
                        && hdr_len < 16'(dhcp6rol_pkg::MSG_HDR_BYTES))
                    begin
                        f_nf = 1'b1;
                    end
                end
                else if (mode_find_reg
                         && (!q_reg.has_after || LW'(opt_reg) > LW'(q_reg.after))
                         && (q_reg.any || hdr_code == q_reg.code))
                begin
                    res_next.found  = 1'b1;
                    res_next.offset = dhcp6rol_pkg::OFFSET_W'(opt_reg);
                    res_next.code   = hdr_code;
                    res_next.length = hdr_len;
                    state_next      = S_DONE;
                end
                else
                begin
                    rem_next   = rem_reg - size;
                    opt_next   = opt_reg + PW'(size);
                    state_next = S_SCAN;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (f_fail)
        begin
            if (!pass_cmd_reg)
            begin
                f_dep_end = 1'b1;
            end
            else if (q_reg.cmd == dhcp6rol_pkg::CMD_MSG)
            begin
                f_msg_end = 1'b1;
            end
            else if (lvl_def)
            begin
                f_nf = 1'b1;
            end
            else
            begin
                // innermost relay lacks a relay message: use its own options
                opt_next       = opt0_reg;
                rem_next       = rem0_reg;
                mode_find_next = 1'b1;
                state_next     = S_SCAN;
            end
        end

        if (f_dep_end)
        begin
            rdepth_next = depth_reg;
            if (q_reg.cmd == dhcp6rol_pkg::CMD_DEPTH)
            begin
                res_next.found  = 1'b1;
                res_next.offset = '0;
                res_next.code   = '0;
                res_next.length = '0;
                state_next      = S_DONE;
            end
            else
            begin
                pass_cmd_next = 1'b1;
                msg_next      = '0;
                len_next      = plen_ext;
                depth_next    = '0;
                state_next    = S_TYPE_RD;
                if (q_reg.cmd == dhcp6rol_pkg::CMD_MSG
                    && plen_ext < LW'(dhcp6rol_pkg::MSG_HDR_BYTES))
                begin
                    f_nf = 1'b1;
                end
            end
        end

        if (f_msg_end)
        begin
            if (lvl_def && depth_reg < lvl)
            begin
                f_nf = 1'b1;
            end
            else
            begin
                res_next.found  = 1'b1;
                res_next.offset = dhcp6rol_pkg::OFFSET_W'(msg_reg);
                res_next.code   = 16'(cur_type);
                res_next.length = len_reg[15:0];
                state_next      = S_DONE;
            end
        end

        if (f_nf)
        begin
            res_next.found  = 1'b0;
            res_next.offset = '0;
            res_next.code   = '0;
            res_next.length = '0;
            state_next      = S_DONE;
        end

        res_next.depth = rdepth_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_cmd_reg  <= pass_cmd_next;
        mode_find_reg <= mode_find_next;
        q_reg         <= q_next;
        msg_reg       <= msg_next;
        len_reg       <= len_next;
        depth_reg     <= depth_next;
        opt_reg       <= opt_next;
        rem_reg       <= rem_next;
        opt0_reg      <= opt0_next;
        rem0_reg      <= rem0_next;
        cnt_reg       <= cnt_next;
        hdr_reg       <= hdr_next;
        type_reg      <= type_next;
        rdepth_reg    <= rdepth_next;
        res_reg       <= res_next;
    end

    assign idle   = (state_reg == S_IDLE);
    assign result = res_reg;

endmodule

>>> rtl/core/dhcp6_relay_option_locator.sv
// load: one byte per cycle while the walker is idle. query: the walker reads the type byte of each
// message level visited and each option header from the byte store's read port, over a depth pass and a
// command pass, then passes the result through the output register; one query in flight at a time.
// reset clears packet length, load and overflow flags and handshake state; the byte
// store is not cleared.
// top level: depends on dhcp6rol_pkg, dhcp6rol_if, dhcp6rol_store, dhcp6rol_walker
`timescale 1ns / 1ps
`include "dhcp6_relay_option_locator_macros.svh"

module dhcp6_relay_option_locator #(
    parameter int BUF_BYTES = dhcp6rol_pkg::BUF_BYTES_DEF,
    parameter int MAX_RELAY = dhcp6rol_pkg::MAX_RELAY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    dhcp6rol_req_if.sink   req,
    dhcp6rol_rsp_if.source rsp
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int PW = AW + 1;

    // packet bookkeeping
    logic [PW-1:0] plen_reg, plen_next;
    logic          open_reg, open_next;
    logic          ovf_reg, ovf_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    dhcp6rol_pkg::result_t out_reg;
    logic                  out_trunc_reg;

    logic                  walk_idle;
    logic                  walk_res_valid;
    dhcp6rol_pkg::result_t walk_result;
    dhcp6rol_pkg::query_t  query;
    logic [AW-1:0]         rd_addr;
    logic [7:0]            rd_data;
    logic                  xfer;
    logic                  is_load;
    logic                  wr_en;
    logic [PW-1:0]         plen_eff;

    // the walker takes no transfer while a query is in progress
    assign req.ready = walk_idle;
    assign xfer      = req.valid && req.ready;
    assign is_load   = dhcp6rol_pkg::cmd_t'(req.command) == dhcp6rol_pkg::CMD_LOAD;

    assign query.cmd       = dhcp6rol_pkg::cmd_t'(req.command);
    assign query.level     = req.target_level;
    assign query.code      = req.option_code;
    assign query.any       = req.match_any;
    assign query.has_after = req.has_after;
    assign query.after     = req.after_offset;

    // first byte of a new packet restarts the length count
    assign plen_eff = open_reg ? plen_reg : '0;
    assign wr_en    = xfer && is_load && (plen_eff < PW'(BUF_BYTES));

    always_comb
    begin
        plen_next = plen_reg;
        open_next = open_reg;
        ovf_next  = ovf_reg;
        if (xfer && is_load)
        begin
            if (!open_reg)
            begin
                ovf_next = 1'b0;
            end
            if (wr_en)
            begin
                plen_next = plen_eff + PW'(1);
            end
            else
            begin
                plen_next = plen_eff;
                ovf_next  = 1'b1;
            end
            open_next = !req.last_byte;
        end
    end

    // result waits in the output register until its transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (walk_res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            open_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plen_reg      <= plen_next;
            open_reg      <= open_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // overflow flag is taken with the result, loads may follow while it waits
    always_ff @(posedge clk)
    begin
        if (walk_res_valid)
        begin
            out_reg       <= walk_result;
            out_trunc_reg <= ovf_reg;
        end
    end

    dhcp6rol_store #(
        .BUF_BYTES (BUF_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (plen_eff[AW-1:0]),
        .wr_data (req.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dhcp6rol_walker #(
        .BUF_BYTES (BUF_BYTES),
        .MAX_RELAY (MAX_RELAY)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (xfer && !is_load),
        .query         (query),
        .packet_length (plen_reg),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_free      (!out_valid_reg || rsp.ready),
        .idle          (walk_idle),
        .res_valid     (walk_res_valid),
        .result        (walk_result)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.found         = out_reg.found;
    assign rsp.relay_depth   = out_reg.depth;
    assign rsp.result_offset = out_reg.offset;
    assign rsp.result_code   = out_reg.code;
    assign rsp.result_length = out_reg.length;
    assign rsp.truncated     = out_trunc_reg;

    // stored length never passes the buffer size
    `DHCP6ROL_ASSERT_IMPLY(a_plen_bound, clk, rst_n, 1'b1, plen_reg <= PW'(BUF_BYTES))
    // overflow only once the buffer is full
    `DHCP6ROL_ASSERT_IMPLY(a_ovf_full, clk, rst_n, ovf_reg, plen_reg == PW'(BUF_BYTES))
    // a walker result never arrives while a new query can be taken
    `DHCP6ROL_ASSERT_IMPLY(a_ready_no_res, clk, rst_n, req.ready, !walk_res_valid)
    // a query transfer keeps the request side closed in the next cycle
    `DHCP6ROL_ASSERT_NEXT(a_query_busy, clk, rst_n, xfer && !is_load, !req.ready)

endmodule

>>> test/testbench.sv
// self-checking testbench of the dhcpv6 relay option locator
// depends on dhcp6rol_pkg, dhcp6rol_if and the rtl of the block
`timescale 1ns / 1ps

module testbench;
    import dhcp6rol_pkg::*;

    localparam int BUF_BYTES  = BUF_BYTES_DEF;
    localparam int MAX_RELAY  = MAX_RELAY_DEF;
    localparam int STALL_LIMIT = 60000;

    typedef byte unsigned bytes_t[$];

    // one request item
    typedef struct {
        cmd_t        cmd;
        logic [7:0]  data;
        logic        last;
        logic [6:0]  level;
        logic [15:0] code;
        logic        any;
        logic        has_after;
        logic [10:0] after;
    } request_t;

    // one response item
    typedef struct {
        logic        found;
        logic [5:0]  depth;
        logic [10:0] offset;
        logic [15:0] code;
        logic [15:0] length;
        logic        trunc;
    } answer_t;

    // directed row: typed answers only where obvious
    typedef struct {
        request_t rq;
        bit       typed;
        answer_t  ans;
    } row_t;

    logic clk;
    logic rst_n;

    dhcp6rol_req_if req ();
    dhcp6rol_rsp_if rsp ();

    dhcp6_relay_option_locator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // local copy of the packet buffer state
    byte unsigned pkt_image [BUF_BYTES];
    int unsigned  pkt_len;
    bit           pkt_open;
    bit           pkt_overflow;

    answer_t pending_answers[$];
    bit      mismatch_seen;
    int      tx_idle_pct;
    int      rx_idle_pct;
    int      sent_items;
    int      quiet_cycles;
    int      cur_levels;
    int      cur_size;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- packet walk predictor ----------------

    function automatic int unsigned rd8(int unsigned a);
        return (a < BUF_BYTES) ? pkt_image[a] : 0;
    endfunction

    function automatic int unsigned rd16(int unsigned a);
        return (rd8(a) << 8) | rd8(a + 1);
    endfunction

    function automatic bit is_relay_msg(int unsigned m);
        int unsigned t;
        t = rd8(m);
        return t == TYPE_RELAY_FORW || t == TYPE_RELAY_REPL;
    endfunction

    // first relay-message option of an option area, fully inside it
    function automatic bit relay_opt_at(int unsigned opt, int unsigned rem,
                                        output int unsigned where);
        int unsigned sz;
        where = 0;
        while (rem >= OPT_HDR_BYTES)
        begin
            sz = OPT_HDR_BYTES + rd16(opt + 2);
            if (rd16(opt) == CODE_RELAY_MSG)
            begin
                if (rem < sz)
                    return 0;
                where = opt;
                return 1;
            end
            if (rem < sz)
                return 0;
            rem -= sz;
            opt += sz;
        end
        return 0;
    endfunction

    function automatic bit opt_span(int unsigned msg, int unsigned len,
                                    output int unsigned opt, output int unsigned rem);
        opt = 0;
        rem = 0;
        if (len < MSG_HDR_BYTES)
            return 0;
        if (is_relay_msg(msg))
        begin
            if (len < RELAY_HDR_BYTES)
                return 0;
            opt = msg + RELAY_HDR_BYTES;
            rem = len - RELAY_HDR_BYTES;
        end
        else
        begin
            opt = msg + MSG_HDR_BYTES;
            rem = len - MSG_HDR_BYTES;
        end
        return 1;
    endfunction

    function automatic int unsigned nest_depth();
        int unsigned msg, len, depth, opt, rem, rm;
        msg = 0;
        len = pkt_len;
        depth = 0;
        while (depth < MAX_RELAY)
        begin
            if (len < RELAY_HDR_BYTES || !is_relay_msg(msg))
                break;
            if (!opt_span(msg, len, opt, rem))
                break;
            if (!relay_opt_at(opt, rem, rm))
                break;
            len = rd16(rm + 2);
            msg = rm + OPT_HDR_BYTES;
            depth++;
        end
        return depth;
    endfunction

    function automatic bit msg_header(int level, output int unsigned msg_o,
                                      output int unsigned len_o);
        int unsigned msg, len, opt, rem, rm;
        int depth;
        msg = 0;
        len = pkt_len;
        depth = 0;
        msg_o = 0;
        len_o = 0;
        if (len < MSG_HDR_BYTES)
            return 0;
        while (depth < MAX_RELAY)
        begin
            if (len < RELAY_HDR_BYTES || !is_relay_msg(msg))
                break;
            if (level >= 0 && depth >= level)
                break;
            if (!opt_span(msg, len, opt, rem))
                break;
            if (!relay_opt_at(opt, rem, rm))
                break;
            len = rd16(rm + 2);
            // inner message too short for a header
            if (len < MSG_HDR_BYTES)
                return 0;
            msg = rm + OPT_HDR_BYTES;
            depth++;
        end
        if (level >= 0 && depth < level)
            return 0;
        msg_o = msg;
        len_o = len;
        return 1;
    endfunction

    function automatic bit opt_search(int level, int unsigned code, bit any,
                                      bit has_after, int unsigned after,
                                      output int unsigned at);
        int unsigned msg, len, opt, rem, rm, sz;
        int depth;
        msg = 0;
        len = pkt_len;
        depth = 0;
        at = 0;
        forever
        begin
            if (depth > MAX_RELAY)
                return 0;
            if (!opt_span(msg, len, opt, rem))
                return 0;
            if (is_relay_msg(msg) && !(level >= 0 && depth >= level))
            begin
                if (relay_opt_at(opt, rem, rm))
                begin
                    len = rd16(rm + 2);
                    msg = rm + OPT_HDR_BYTES;
                    depth++;
                    continue;
                end
                // relay without relay-message: only innermost falls back to it
                if (level >= 0)
                    return 0;
            end
            break;
        end
        if (level >= 0 && level != depth)
            return 0;
        while (rem >= OPT_HDR_BYTES)
        begin
            sz = OPT_HDR_BYTES + rd16(opt + 2);
            if (rem < sz)
                return 0;
            if ((!has_after || opt > after) && (any || rd16(opt) == code))
            begin
                at = opt;
                return 1;
            end
            rem -= sz;
            opt += sz;
        end
        return 0;
    endfunction

    // applies one accepted request, returns 1 and the answer for a query
    function automatic bit locate_answer(request_t rq, output answer_t ans);
        int unsigned m, l, at;
        int lvl;
        lvl = $signed(rq.level);
        ans = '{default: '0};
        if (rq.cmd == CMD_LOAD)
        begin
            if (!pkt_open)
            begin
                pkt_len = 0;
                pkt_overflow = 0;
                pkt_open = 1;
            end
            if (pkt_len < BUF_BYTES)
            begin
                pkt_image[pkt_len] = rq.data;
                pkt_len++;
            end
            else
                pkt_overflow = 1;
            if (rq.last)
                pkt_open = 0;
            return 0;
        end
        if (rq.cmd == CMD_DEPTH)
            ans.found = 1;
        else if (rq.cmd == CMD_MSG)
        begin
            if (msg_header(lvl, m, l))
            begin
                ans.found = 1;
                ans.offset = m;
                ans.code = rd8(m);
                ans.length = l;
            end
        end
        else if (opt_search(lvl, rq.code, rq.any, rq.has_after, rq.after, at))
        begin
            ans.found = 1;
            ans.offset = at;
            ans.code = rd16(at);
            ans.length = rd16(at + 2);
        end
        ans.depth = nest_depth();
        ans.trunc = pkt_overflow;
        return 1;
    endfunction

    // ---------------- request side ----------------

    task automatic send(request_t rq, bit typed = 0, answer_t typed_ans = '{default: '0});
        answer_t ans;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.command      <= rq.cmd;
        req.data_byte    <= rq.data;
        req.last_byte    <= rq.last;
        req.target_level <= rq.level;
        req.option_code  <= rq.code;
        req.match_any    <= rq.any;
        req.has_after    <= rq.has_after;
        req.after_offset <= rq.after;
        do
            @(posedge clk);
        while (!req.ready);
        if (locate_answer(rq, ans))
            pending_answers.push_back(typed ? typed_ans : ans);
        sent_items++;
    endtask

    // sender goes quiet so the last transfer is not taken twice
    task automatic wait_answers();
        req.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic request_t random_query();
        request_t rq;
        logic [15:0] pool [6] = '{16'd1, 16'd2, 16'd3, 16'd9, 16'd0, 16'hFFFF};
        rq.cmd = cmd_t'($urandom_range(1, 3));
        rq.data = $urandom;
        rq.last = $urandom;
        if ($urandom_range(99) < 70)
            rq.level = ($urandom_range(9) == 0) ? 7'h7F : $urandom_range(0, cur_levels + 1);
        else
            rq.level = $urandom;
        rq.code = ($urandom_range(3) == 0) ? 16'($urandom) : pool[$urandom_range(5)];
        rq.any = $urandom;
        rq.has_after = $urandom;
        rq.after = ($urandom_range(3) == 0) ? 11'($urandom) : $urandom_range(0, cur_size);
        return rq;
    endfunction

    task automatic load_packet(bytes_t p, int query_pct);
        request_t rq;
        rq = '{cmd: CMD_LOAD, default: '0};
        foreach (p[i])
        begin
            rq.data = p[i];
            rq.last = (i == p.size() - 1);
            rq.level = $urandom;
            rq.code = $urandom;
            rq.after = $urandom;
            send(rq);
            // queries that see a partly loaded packet
            if (!rq.last && $urandom_range(99) < query_pct)
                send(random_query());
        end
    endtask

    function automatic void add_option(ref bytes_t m, input int unsigned code,
                                       input int unsigned len);
        m.push_back(code >> 8);
        m.push_back(code & 8'hFF);
        m.push_back(len >> 8);
        m.push_back(len & 8'hFF);
        repeat (len) m.push_back($urandom);
    endfunction

    function automatic int unsigned pick_code();
        int unsigned codes [5] = '{1, 2, 3, 0, 16'hFFFF};
        return ($urandom_range(4) == 0) ? $urandom_range(0, 16'hFFFF)
                                        : codes[$urandom_range(4)];
    endfunction

    // well-formed message with the given number of relay levels around it
    function automatic bytes_t make_msg(int levels, int opts);
        bytes_t m, inner;
        if (levels > 0)
        begin
            m.push_back($urandom_range(1) ? TYPE_RELAY_FORW : TYPE_RELAY_REPL);
            repeat (RELAY_HDR_BYTES - 1) m.push_back($urandom);
            repeat ($urandom_range(0, opts)) add_option(m, pick_code(), $urandom_range(0, 4));
            inner = make_msg(levels - 1, opts);
            add_option(m, CODE_RELAY_MSG, 0);
            m[m.size() - 2] = inner.size() >> 8;
            m[m.size() - 1] = inner.size() & 8'hFF;
            m = {m, inner};
            repeat ($urandom_range(0, opts)) add_option(m, pick_code(), $urandom_range(0, 4));
        end
        else
        begin
            m.push_back(($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 11));
            repeat (MSG_HDR_BYTES - 1) m.push_back($urandom);
            repeat ($urandom_range(0, opts + 2))
                add_option(m, ($urandom_range(7) == 0) ? CODE_RELAY_MSG : pick_code(),
                           $urandom_range(0, 6));
        end
        return m;
    endfunction

    task automatic random_packet_with_queries(int levels);
        bytes_t p;
        int k;
        k = $urandom_range(99);
        if (k < 10)
        begin
            // noise
            repeat ($urandom_range(1, 50)) p.push_back($urandom);
            if ($urandom_range(1) != 0)
                p[0] = $urandom_range(1) ? TYPE_RELAY_FORW : TYPE_RELAY_REPL;
        end
        else
        begin
            p = make_msg(levels, 2);
            if (k < 25)
                p[$urandom_range(p.size() - 1)] = $urandom;          // byte damage
            else if (k < 35)
                p = p[0 : $urandom_range(p.size() - 1)];              // cut short
            else if (k < 40)
                p[$urandom_range(p.size() - 1)] = 8'hFF;              // overlong length
        end
        cur_levels = levels;
        cur_size = p.size();
        load_packet(p, 4);
        repeat ($urandom_range(4, 14)) send(random_query());
    endtask

    // ---------------- response side and watchdog ----------------

    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (rsp.valid && rsp.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected response transfer", $time);
                    mismatch_seen = 1;
                end
                else
                begin
                    exp_ans = pending_answers.pop_front();
                    if (rsp.found !== exp_ans.found)
                    begin
                        $display("%0t found exp %0d act %0d", $time, exp_ans.found, rsp.found);
                        mismatch_seen = 1;
                    end
                    if (rsp.relay_depth !== exp_ans.depth)
                    begin
                        $display("%0t relay_depth exp %0d act %0d", $time, exp_ans.depth,
                                 rsp.relay_depth);
                        mismatch_seen = 1;
                    end
                    if (rsp.result_offset !== exp_ans.offset)
                    begin
                        $display("%0t result_offset exp %0d act %0d", $time, exp_ans.offset,
                                 rsp.result_offset);
                        mismatch_seen = 1;
                    end
                    if (rsp.result_code !== exp_ans.code)
                    begin
                        $display("%0t result_code exp %h act %h", $time, exp_ans.code,
                                 rsp.result_code);
                        mismatch_seen = 1;
                    end
                    if (rsp.result_length !== exp_ans.length)
                    begin
                        $display("%0t result_length exp %0d act %0d", $time, exp_ans.length,
                                 rsp.result_length);
                        mismatch_seen = 1;
                    end
                    if (rsp.truncated !== exp_ans.trunc)
                    begin
                        $display("%0t truncated exp %0d act %0d", $time, exp_ans.trunc,
                                 rsp.truncated);
                        mismatch_seen = 1;
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("Mismatches found");
                $finish;
            end
            rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ---------------- stimulus ----------------

    initial
    begin
        row_t    rows[$];
        request_t q;
        answer_t none;
        bytes_t  big;
        int      phase;
        int      n;

        clk = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.command = CMD_LOAD;
        req.data_byte = '0;
        req.last_byte = 1'b0;
        req.target_level = '0;
        req.option_code = '0;
        req.match_any = 1'b0;
        req.has_after = 1'b0;
        req.after_offset = '0;
        rsp.ready = 1'b0;
        pkt_len = 0;
        pkt_open = 0;
        pkt_overflow = 0;
        foreach (pkt_image[i])
            pkt_image[i] = 0;
        mismatch_seen = 0;
        quiet_cycles = 0;
        sent_items = 0;
        tx_idle_pct = 18;
        rx_idle_pct = 78;
        none = '{default: '0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty buffer, then a tiny plain message with one option
        q = '{cmd: CMD_DEPTH, default: '0};
        rows.push_back('{q, 1, '{1, 0, 0, 0, 0, 0}});
        q = '{cmd: CMD_MSG, level: 7'h7F, default: '0};
        rows.push_back('{q, 1, none});
        q = '{cmd: CMD_FIND, any: 1, default: '0};
        rows.push_back('{q, 1, none});
        foreach (big[i]) big.delete();
        big = '{8'h01, 8'hAA, 8'hBB, 8'hCC, 8'hFF, 8'hFF, 8'h00, 8'h00};
        foreach (big[i])
        begin
            q = '{cmd: CMD_LOAD, data: big[i], last: (i == 7), default: '0};
            rows.push_back('{q, 0, none});
            if (i == 5)
            begin
                // query on the half loaded packet
                q = '{cmd: CMD_FIND, any: 1, default: '0};
                rows.push_back('{q, 0, none});
            end
        end
        q = '{cmd: CMD_FIND, code: 16'hFFFF, default: '0};
        rows.push_back('{q, 1, '{1, 0, 4, 16'hFFFF, 0, 0}});
        q = '{cmd: CMD_MSG, default: '0};
        rows.push_back('{q, 1, '{1, 0, 0, 1, 8, 0}});
        q = '{cmd: CMD_MSG, level: 7'd1, default: '0};
        rows.push_back('{q, 1, none});
        q = '{cmd: CMD_MSG, level: 7'h40, default: '0};
        rows.push_back('{q, 1, '{1, 0, 0, 1, 8, 0}});
        q = '{cmd: CMD_FIND, level: 7'd32, any: 1, default: '0};
        rows.push_back('{q, 1, none});
        q = '{cmd: CMD_FIND, any: 1, has_after: 1, after: 11'd4, default: '0};
        rows.push_back('{q, 1, none});
        q = '{cmd: CMD_FIND, any: 1, has_after: 1, after: 11'd3, default: '0};
        rows.push_back('{q, 0, none});
        q = '{cmd: CMD_FIND, any: 1, has_after: 1, after: 11'h7FF, default: '0};
        rows.push_back('{q, 1, none});
        q = '{cmd: CMD_FIND, code: 16'h0000, level: 7'h7F, default: '0};
        rows.push_back('{q, 1, none});
        foreach (rows[i])
            send(rows[i].rq, rows[i].typed, rows[i].ans);

        // random: sender light / receiver heavy, swapped, then free running
        for (phase = 0; phase < 3; phase++)
        begin
            // sender holds off until everything is back
            wait_answers();
            tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 78 : 0;
            rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 18 : 0;
            if (phase == 2)
            begin
                // deepest nesting, past the relay limit
                big = make_msg(MAX_RELAY + 1, 0);
                cur_levels = MAX_RELAY;
                cur_size = big.size();
                load_packet(big, 0);
                repeat (16) send(random_query());
                // buffer overflow
                big = make_msg(1, 2);
                n = big.size();
                big[n - 1] = 8'h00;
                repeat (BUF_BYTES + 12 - n) big.push_back($urandom);
                cur_levels = 1;
                cur_size = BUF_BYTES;
                load_packet(big, 0);
                repeat (12) send(random_query());
            end
            n = sent_items + 430;
            while (sent_items < n)
                random_packet_with_queries(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4));
        end
        req.valid <= 1'b0;

        wait_answers();
        repeat (100) @(posedge clk);
        if (!mismatch_seen)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> dhcp6_relay_option_locator.f
+incdir+rtl/core
rtl/core/dhcp6rol_pkg.sv
rtl/core/dhcp6rol_if.sv
rtl/core/dhcp6rol_store.sv
rtl/core/dhcp6rol_walker.sv
rtl/core/dhcp6_relay_option_locator.sv
test/testbench.sv
